### hw/rtl/dsr_pkg.sv
// shared types and constants for the datagram sequence reassembly receive core
// no dependencies
package dsr_pkg;

   localparam int FRAG_BYTES_DEF = 1024;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   localparam logic [1:0] VERDICT_STALE    = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_STORED   = 2'd2;
   localparam logic [1:0] VERDICT_DELIVER  = 2'd3;

   typedef struct packed {
      logic [31:0] seq_word;
      logic [15:0] frag_offset;
      logic [15:0] frag_len;
      logic [15:0] payload_len;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic        gap_seen;
      logic        restarted;
      logic [15:0] write_offset;
      logic [15:0] deliver_len;
      logic [30:0] deliver_seq;
   } rsp_type;

   // decoded header as it waits between the front and the back
   typedef struct packed {
      logic        frag;
      logic [30:0] seq;
      logic        last_frag;
      logic [15:0] frag_offset;
      logic [15:0] payload_len;
   } cmd_type;

endpackage

### hw/rtl/datagram_sequence_reassembly_rx_core.sv
// Datagram sequence reassembly, receive side: one result item per header item.
// req channel carries a received header (sequence word, fragment offset and
// length, payload byte count); rsp channel returns the verdict, gap and restart
// flags, the write offset into the external reassembly store, the delivered
// length and the sequence number.
// An item accepted by the front is decoded and written into a two-entry
// queue; the back takes it from the queue when the result register is free
// or not stalled, updates the sequence and gathering state and loads the
// result register, which drives rsp_valid. Throughput is one item per cycle
// while rsp_stall is low, set by the compare and saturating add in the back.
// A stalled result holds in the output register while the queue keeps taking
// items; req_stall rises only when the queue is full.
// Synchronous reset clears the last sequence, the gathering state, the queue
// pointers and count, and the result valid flag; no clearing pass is needed.
// Depends on dsr_pkg, dsr_front, dsr_queue, dsr_back.
module datagram_sequence_reassembly_rx_core #(
   parameter int FRAG_BYTES = dsr_pkg::FRAG_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsr_pkg::rsp_type rsp_data
);
   import dsr_pkg::*;

   logic    queue_full;
   logic    push_valid;
   cmd_type push_data;
   logic    pop_valid;
   cmd_type pop_data;
   logic    pop;

   dsr_front #(
      .FRAG_BYTES (FRAG_BYTES)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   dsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   dsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_data  (pop_data),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // the result register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stale item changes nothing and reports no gap, restart or store
   a_stale_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict == VERDICT_STALE |->
         !rsp_data.gap_seen && !rsp_data.restarted &&
         rsp_data.write_offset == '0 && rsp_data.deliver_len == '0)
      else $error("stale item carries side effects");

   // only a delivery reports a length
   a_len_only_on_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict != VERDICT_DELIVER |-> rsp_data.deliver_len == '0)
      else $error("length reported without delivery");

   // dropped items never get a store offset
   a_no_offset_on_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict == VERDICT_MISMATCH |-> rsp_data.write_offset == '0)
      else $error("store offset on a dropped fragment");

endmodule

### hw/rtl/dsr_front.sv
// front end: accepts header items and decodes them into queue commands
// depends on dsr_pkg
module dsr_front #(
   parameter int FRAG_BYTES = dsr_pkg::FRAG_BYTES_DEF
) (
   input  logic             req_valid,
   output logic             req_stall,
   input  dsr_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             push_valid,
   output dsr_pkg::cmd_type push_data
);
   import dsr_pkg::*;

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_data.frag        = req_data.seq_word[31];
      push_data.seq         = req_data.seq_word[30:0];
      // a length at or above the fragment size marks a fragment that is not the last
      push_data.last_frag   = {1'b0, req_data.frag_len} < 17'(FRAG_BYTES);
      push_data.frag_offset = req_data.frag_offset;
      push_data.payload_len = req_data.payload_len;
   end

endmodule

### hw/rtl/dsr_queue.sv
// short command queue between the front and the back
// depends on dsr_pkg
module dsr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  dsr_pkg::cmd_type push_data,
   output logic             full,
   output logic             pop_valid,
   output dsr_pkg::cmd_type pop_data,
   input  logic             pop
);
   import dsr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/dsr_back.sv
// back end: sequence and gathering state, verdicts and the result register
// depends on dsr_pkg
module dsr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  dsr_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsr_pkg::rsp_type rsp_data
);
   import dsr_pkg::*;

   logic [30:0] last_in_seq_ff, last_in_seq_in;
   logic [30:0] gather_seq_ff, gather_seq_in;
   logic        gather_valid_ff, gather_valid_in;
   logic [15:0] gathered_len_ff, gathered_len_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic        issue;
   logic        stale;
   logic        restart;
   logic [15:0] base_len;
   logic [16:0] sum;
   logic [15:0] sat_len;

   assign issue   = cmd_valid && (!out_valid_ff || !rsp_stall);
   assign cmd_pop = issue;

   always_comb begin
      stale    = (cmd_data.seq <= last_in_seq_ff) && (last_in_seq_ff != '0);
      restart  = cmd_data.frag && !stale &&
                 (!gather_valid_ff || (cmd_data.seq != gather_seq_ff));
      base_len = restart ? '0 : gathered_len_ff;
      sum      = {1'b0, base_len} + {1'b0, cmd_data.payload_len};
      sat_len  = sum[16] ? LEN_MAX : sum[15:0];

      last_in_seq_in  = last_in_seq_ff;
      gather_seq_in   = gather_seq_ff;
      gather_valid_in = gather_valid_ff;
      gathered_len_in = gathered_len_ff;

      out_in.verdict      = VERDICT_STALE;
      out_in.gap_seen     = 1'b0;
      out_in.restarted    = restart;
      out_in.write_offset = '0;
      out_in.deliver_len  = '0;
      out_in.deliver_seq  = cmd_data.seq;

      if (!stale) begin
         out_in.gap_seen = {1'b0, cmd_data.seq} > ({1'b0, last_in_seq_ff} + 32'd1);
         if (!cmd_data.frag) begin
            out_in.verdict     = VERDICT_DELIVER;
            out_in.deliver_len = cmd_data.payload_len;
            last_in_seq_in     = cmd_data.seq;
         end else begin
            // a restart holds even if the fragment is then dropped
            if (restart) begin
               gather_seq_in   = cmd_data.seq;
               gather_valid_in = 1'b1;
               gathered_len_in = '0;
            end
            if (cmd_data.frag_offset != base_len) begin
               out_in.verdict = VERDICT_MISMATCH;
            end else begin
               out_in.write_offset = base_len;
               if (cmd_data.last_frag) begin
                  out_in.verdict     = VERDICT_DELIVER;
                  out_in.deliver_len = sat_len;
                  last_in_seq_in     = cmd_data.seq;
                  gathered_len_in    = '0;
               end else begin
                  out_in.verdict  = VERDICT_STORED;
                  gathered_len_in = sat_len;
               end
            end
         end
      end

      if (issue) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_in_seq_ff  <= '0;
         gather_seq_ff   <= '0;
         gather_valid_ff <= 1'b0;
         gathered_len_ff <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (issue) begin
            last_in_seq_ff  <= last_in_seq_in;
            gather_seq_ff   <= gather_seq_in;
            gather_valid_ff <= gather_valid_in;
            gathered_len_ff <= gathered_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
